// ----- sv/bvtc_pkg.sv -----
// ----------------------------------------------------------------------------
// bvtc_pkg
// Shared constants, types and helpers of the block vote-table classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bvtc_pkg;

    // Default sizes
    localparam int NUM_BLOCKS_DEF  = 84;
    localparam int NUM_CLASSES_DEF = 10;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed geometry
    localparam int CODES     = 27;
    localparam int CODE_W    = 5;
    localparam int TOTAL_W   = 40;
    localparam int BLK_W     = 7;
    localparam int LBL_W     = 4;
    localparam int CLASS_W   = 4;
    localparam int TRIT_W    = 2;

    localparam logic [CODE_W-1:0] BG_CODE_RESET = 5'd13;

    // Action codes
    localparam logic ACT_TRAIN    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
        logic arg_step;
        logic emit;
    } bvtc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic do_argmax;
        logic arg_done;
        logic out_free;
    } bvtc_sts_t;

    // Trit to offset 0..2; the unused pattern counts as -1
    function automatic logic [1:0] trit_offset(input logic [TRIT_W-1:0] raw);
        logic [1:0] off;
        case (raw)
            2'b00:   off = 2'd1;
            2'b01:   off = 2'd2;
            default: off = 2'd0;
        endcase
        return off;
    endfunction

    // 9*(a+1) + 3*(b+1) + (c+1)
    function automatic logic [CODE_W-1:0] block_code(input logic [TRIT_W-1:0] a,
                                                     input logic [TRIT_W-1:0] b,
                                                     input logic [TRIT_W-1:0] c);
        logic [CODE_W-1:0] oa;
        logic [CODE_W-1:0] ob;
        logic [CODE_W-1:0] oc;
        oa = CODE_W'(trit_offset(a));
        ob = CODE_W'(trit_offset(b));
        oc = CODE_W'(trit_offset(c));
        return CODE_W'(oa * CODE_W'(9) + ob * CODE_W'(3) + oc);
    endfunction

endpackage

`default_nettype wire

// ----- sv/block_vote_table_classifier.sv -----
// ----------------------------------------------------------------------------
// block_vote_table_classifier
// Vote-table classifier over ternary block codes: trains per-class counters
// and classifies samples by summing votes and picking the strongest class.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  item     | item_valid / item_stall   | action, trit_a/b/c, block_index,
//           |                           | class_label, last_block
//  result   | result_valid/result_stall | predicted_class
//  config   | cfg_we                    | cfg_data (background code)
//
//  A request goes through a table row read, then update or accumulate.
//  A classify request with last_block adds an argmax walk over the class
//  totals (one class total compared per cycle), then loads the result.
//  After reset the table is zeroed one row per cycle with item_stall high.
//  A stalled result holds; only a finishing classify waits for it to go.
// ----------------------------------------------------------------------------
`default_nettype none

module block_vote_table_classifier #(
    parameter int NUM_BLOCKS  = bvtc_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_CLASSES = bvtc_pkg::NUM_CLASSES_DEF,
    parameter int COUNT_WIDTH = bvtc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [bvtc_pkg::CODE_W-1:0]   cfg_data,
    // request channel
    input  wire logic                          item_valid,
    output      logic                          item_stall,
    input  wire logic                          action,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_a,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_b,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_c,
    input  wire logic [bvtc_pkg::BLK_W-1:0]    block_index,
    input  wire logic [bvtc_pkg::LBL_W-1:0]    class_label,
    input  wire logic                          last_block,
    // result channel
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic [bvtc_pkg::CLASS_W-1:0]  predicted_class
);

    bvtc_pkg::bvtc_cmd_t ctrl_cmd;
    bvtc_pkg::bvtc_sts_t ctrl_sts;

    // Sequencer: owns item_stall, steps the datapath
    bvtc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (ctrl_sts),
        .cmd        (ctrl_cmd)
    );

    // Table memory, totals, argmax, output register
    bvtc_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctrl_cmd),
        .sts             (ctrl_sts),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .action          (action),
        .trit_a          (trit_a),
        .trit_b          (trit_b),
        .trit_c          (trit_c),
        .block_index     (block_index),
        .class_label     (class_label),
        .last_block      (last_block),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .predicted_class (predicted_class)
    );

    // ---------------------------------------------------------------- checks

    // No request taken while the table is still being zeroed
    a_no_intake_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_sts.clear_done |-> item_stall)
        else $error("request accepted during table clear");

    // One request in flight: intake closes right after an accept
    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second request accepted while busy");

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl_cmd.clr_step, ctrl_cmd.load, ctrl_cmd.exec,
                  ctrl_cmd.arg_step, ctrl_cmd.emit}))
        else $error("conflicting datapath commands");

    // A loaded result shows up on the port next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.emit |=> result_valid)
        else $error("result lost after emit");

endmodule

`default_nettype wire

// ----- sv/bvtc_datapath.sv -----
// ----------------------------------------------------------------------------
// bvtc_datapath
// Vote-table memory, class totals, argmax search and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvtc_datapath #(
    parameter int NUM_BLOCKS  = bvtc_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_CLASSES = bvtc_pkg::NUM_CLASSES_DEF,
    parameter int COUNT_WIDTH = bvtc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bvtc_pkg::bvtc_cmd_t           cmd,
    output      bvtc_pkg::bvtc_sts_t           sts,
    input  wire logic                          cfg_we,
    input  wire logic [bvtc_pkg::CODE_W-1:0]   cfg_data,
    input  wire logic                          action,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_a,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_b,
    input  wire logic [bvtc_pkg::TRIT_W-1:0]   trit_c,
    input  wire logic [bvtc_pkg::BLK_W-1:0]    block_index,
    input  wire logic [bvtc_pkg::LBL_W-1:0]    class_label,
    input  wire logic                          last_block,
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic [bvtc_pkg::CLASS_W-1:0]  predicted_class
);

    localparam int ROWS    = NUM_BLOCKS * bvtc_pkg::CODES;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int ROW_W   = NUM_CLASSES * COUNT_WIDTH;
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int TW      = bvtc_pkg::TOTAL_W;

    // Table: one row holds all class counters of one (block, code)
    logic [ROW_W-1:0] vote_mem [ROWS];

    logic [ROW_W-1:0]                 rd_row_reg;
    logic [ROW_AW-1:0]                addr_reg;
    logic                             act_reg;
    logic                             last_reg;
    logic                             blk_ok_reg;
    logic                             lbl_ok_reg;
    logic                             skip_reg;
    logic [bvtc_pkg::LBL_W-1:0]       lbl_reg;
    logic [bvtc_pkg::CODE_W-1:0]      bg_reg;
    logic [ROW_AW-1:0]                row_cnt_reg;
    logic                             clear_done_reg;
    logic [TW-1:0]                    totals_reg [NUM_CLASSES];
    logic [TW-1:0]                    totals_next [NUM_CLASSES];
    logic [TW:0]                      sum_c [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0]           lane [NUM_CLASSES];
    logic [ROW_W-1:0]                 row_inc;
    logic [CLS_W-1:0]                 k_reg;
    logic [CLS_W-1:0]                 best_idx_reg;
    logic [TW-1:0]                    best_val_reg;
    logic                             result_valid_reg;
    logic [bvtc_pkg::CLASS_W-1:0]     result_class_reg;

    logic [bvtc_pkg::CODE_W-1:0]      item_code;
    logic [ROW_AW-1:0]                item_addr;
    logic                             item_blk_ok;
    logic                             item_lbl_ok;
    logic                             mem_we;
    logic [ROW_AW-1:0]                mem_wr_addr;
    logic [ROW_W-1:0]                 mem_wr_data;
    logic                             do_train;
    logic                             do_accum;
    logic [TW-1:0]                    cand;

    // Item decode
    assign item_code   = bvtc_pkg::block_code(trit_a, trit_b, trit_c);
    assign item_blk_ok = 32'(block_index) < 32'(NUM_BLOCKS);
    assign item_lbl_ok = 32'(class_label) < 32'(NUM_CLASSES);
    assign item_addr   = ROW_AW'(ROW_AW'(block_index) * ROW_AW'(bvtc_pkg::CODES)
                                 + ROW_AW'(item_code));

    // Saturating increment of the labelled lane
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            lane[c] = rd_row_reg[c*COUNT_WIDTH +: COUNT_WIDTH];
            if ((lbl_reg == bvtc_pkg::LBL_W'(c)) && !(&lane[c]))
                row_inc[c*COUNT_WIDTH +: COUNT_WIDTH] = lane[c] + COUNT_WIDTH'(1);
            else
                row_inc[c*COUNT_WIDTH +: COUNT_WIDTH] = lane[c];
        end
    end

    assign do_train = cmd.exec && (act_reg == bvtc_pkg::ACT_TRAIN)
                      && blk_ok_reg && lbl_ok_reg;
    assign do_accum = cmd.exec && (act_reg == bvtc_pkg::ACT_CLASSIFY)
                      && blk_ok_reg && !skip_reg;

    assign mem_we      = cmd.clr_step || do_train;
    assign mem_wr_addr = cmd.clr_step ? row_cnt_reg : addr_reg;
    assign mem_wr_data = cmd.clr_step ? '0 : row_inc;

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vote_mem[mem_wr_addr] <= mem_wr_data;
        if (cmd.load)
            rd_row_reg <= vote_mem[item_addr];
    end

    // Item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg   <= item_addr;
            act_reg    <= action;
            last_reg   <= last_block;
            blk_ok_reg <= item_blk_ok;
            lbl_ok_reg <= item_lbl_ok;
            skip_reg   <= (item_code == bg_reg);
            lbl_reg    <= class_label;
        end
    end

    // Configuration and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg         <= bvtc_pkg::BG_CODE_RESET;
            row_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bg_reg <= cfg_data;
            if (cmd.clr_step)
            begin
                if (row_cnt_reg == ROW_AW'(ROWS - 1))
                    clear_done_reg <= 1'b1;
                else
                    row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
            end
        end
    end

    // Class totals, saturating at 2^40-1
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            sum_c[c]       = {1'b0, totals_reg[c]} + (TW+1)'(lane[c]);
            totals_next[c] = totals_reg[c];
            if (do_accum)
                totals_next[c] = sum_c[c][TW] ? {TW{1'b1}} : sum_c[c][TW-1:0];
            if (cmd.emit)
                totals_next[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
                totals_reg[c] <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
                totals_reg[c] <= totals_next[c];
        end
    end

    // Argmax: one class per cycle, strict compare keeps the lower index
    assign cand = totals_reg[k_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            k_reg        <= '0;
            best_idx_reg <= '0;
            best_val_reg <= '0;
        end
        else if (cmd.arg_step)
        begin
            if (cand > best_val_reg)
            begin
                best_idx_reg <= k_reg;
                best_val_reg <= cand;
            end
            if (k_reg != CLS_W'(NUM_CLASSES - 1))
                k_reg <= k_reg + CLS_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.emit)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            result_class_reg <= bvtc_pkg::CLASS_W'(best_idx_reg);
    end

    assign result_valid    = result_valid_reg;
    assign predicted_class = result_class_reg;

    assign sts.clear_done = clear_done_reg;
    assign sts.do_argmax  = (act_reg == bvtc_pkg::ACT_CLASSIFY) && last_reg;
    assign sts.arg_done   = (k_reg == CLS_W'(NUM_CLASSES - 1));
    assign sts.out_free   = !result_valid_reg || !result_stall;

endmodule

`default_nettype wire

// ----- sv/bvtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bvtc_ctrl
// Sequencer: clearing pass, request intake, update, argmax and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bvtc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output      logic                 item_stall,
    input  wire bvtc_pkg::bvtc_sts_t  sts,
    output      bvtc_pkg::bvtc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ARG,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = !sts.clear_done;
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.load = item_valid;
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.do_argmax ? ST_ARG : ST_IDLE;
            end
            ST_ARG:
            begin
                cmd.arg_step = 1'b1;
                if (sts.arg_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign item_stall = stall_reg;

endmodule

`default_nettype wire

// ----- sim/bvtc_vote_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bvtc_vote_checker
// Watches the request, result and configuration ports of the vote-table
// classifier, keeps its own copy of the vote table and class totals, and
// compares every accepted class result with the oldest predicted one.
// ----------------------------------------------------------------------------

module bvtc_vote_checker
    import bvtc_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CODE_W-1:0]  cfg_data,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic               action,
    input  logic [TRIT_W-1:0]  trit_a,
    input  logic [TRIT_W-1:0]  trit_b,
    input  logic [TRIT_W-1:0]  trit_c,
    input  logic [BLK_W-1:0]   block_index,
    input  logic [LBL_W-1:0]   class_label,
    input  logic               last_block,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [CLASS_W-1:0] predicted_class,
    output int                 pending,
    output int                 fail_count
);

    localparam int ROWS = NUM_BLOCKS * CODES;

    logic [COUNT_WIDTH-1:0] votes [ROWS*NUM_CLASSES];
    logic [TOTAL_W-1:0]     totals [NUM_CLASSES];
    logic [CODE_W-1:0]      skip_code;
    logic [CLASS_W-1:0]     winner_q [$];

    // -1 and the unused pattern both rank 0
    function automatic int trit_rank(input logic signed [TRIT_W-1:0] t);
        return (t < 0) ? 0 : int'(t) + 1;
    endfunction

    task automatic tally_request();
        int                 code;
        int                 row;
        int                 best;
        logic [TOTAL_W:0]   sum;
        code = 9 * trit_rank(trit_a) + 3 * trit_rank(trit_b) + trit_rank(trit_c);
        row  = (int'(block_index) * CODES + code) * NUM_CLASSES;
        if (action == ACT_TRAIN)
        begin
            if (block_index < NUM_BLOCKS && class_label < NUM_CLASSES)
                if (votes[row + int'(class_label)] != '1)
                    votes[row + int'(class_label)] += 1'b1;
        end
        else
        begin
            if (block_index < NUM_BLOCKS && code != int'(skip_code))
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    sum = {1'b0, totals[c]} + (TOTAL_W+1)'(votes[row + c]);
                    totals[c] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                end
            if (last_block)
            begin
                best = 0;
                for (int c = 1; c < NUM_CLASSES; c++)
                    if (totals[c] > totals[best])
                        best = c;
                winner_q.push_back(CLASS_W'(best));
                foreach (totals[c])
                    totals[c] = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (votes[i])
                votes[i] = '0;
            foreach (totals[c])
                totals[c] = '0;
            skip_code = BG_CODE_RESET;
            winner_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                skip_code = cfg_data;
            // result first: it belongs to an older request than one taken now
            if (result_valid && !result_stall)
            begin
                if (winner_q.size() == 0)
                begin
                    $error("predicted_class: expected no result, actual %0d",
                           predicted_class);
                    fail_count++;
                end
                else if (predicted_class !== winner_q[0])
                begin
                    $error("predicted_class: expected %0d, actual %0d",
                           winner_q[0], predicted_class);
                    fail_count++;
                    void'(winner_q.pop_front());
                end
                else
                    void'(winner_q.pop_front());
            end
            if (item_valid && !item_stall)
                tally_request();
            pending <= winner_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the block vote-table classifier. A short directed
// run covers the corner cases, then random train/classify traffic runs under
// several background codes with bursty requests and a stalling receiver.
// Checking is done by bvtc_vote_checker alongside the block.
// ----------------------------------------------------------------------------

module tb_top;

    import bvtc_pkg::*;

    // Trit encodings as seen on the wire; the clamp pattern is the unused -2
    localparam logic [TRIT_W-1:0] TRIT_NEG   = 2'b11;
    localparam logic [TRIT_W-1:0] TRIT_ZERO  = 2'b00;
    localparam logic [TRIT_W-1:0] TRIT_POS   = 2'b01;
    localparam logic [TRIT_W-1:0] TRIT_CLAMP = 2'b10;

    localparam int ITEM_TARGET   = 550;
    localparam int RESULT_TARGET = 40;
    localparam int PHASE_ITEMS   = 90;
    // covers a request, the argmax walk and the result load, with margin
    localparam int SETTLE_CYCLES = 2 + NUM_CLASSES_DEF + 6;

    typedef struct packed {
        logic              act;
        logic [TRIT_W-1:0] ta;
        logic [TRIT_W-1:0] tb;
        logic [TRIT_W-1:0] tc;
        logic [BLK_W-1:0]  blk;
        logic [LBL_W-1:0]  lbl;
        logic              last;
    } vote_request_t;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_EVERY3} stall_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CODE_W-1:0]  cfg_data     = '0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic               action       = ACT_TRAIN;
    logic [TRIT_W-1:0]  trit_a       = TRIT_ZERO;
    logic [TRIT_W-1:0]  trit_b       = TRIT_ZERO;
    logic [TRIT_W-1:0]  trit_c       = TRIT_ZERO;
    logic [BLK_W-1:0]   block_index  = '0;
    logic [LBL_W-1:0]   class_label  = '0;
    logic               last_block   = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [CLASS_W-1:0] predicted_class;

    int pending;
    int fail_count;

    // request bookkeeping for the stop rule and the summary
    int sent_total   = 0;
    int sent_train   = 0;
    int sent_classify = 0;
    int sent_samples = 0;
    int burst_left   = 1;
    int phase_count  = 0;

    block_vote_table_classifier uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .action          (action),
        .trit_a          (trit_a),
        .trit_b          (trit_b),
        .trit_c          (trit_c),
        .block_index     (block_index),
        .class_label     (class_label),
        .last_block      (last_block),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .predicted_class (predicted_class)
    );

    bvtc_vote_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .action          (action),
        .trit_a          (trit_a),
        .trit_b          (trit_b),
        .trit_c          (trit_c),
        .block_index     (block_index),
        .class_label     (class_label),
        .last_block      (last_block),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .predicted_class (predicted_class),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: switches at random between stall behaviours, so there are
    // spells of no back-pressure as well as heavy and regular stalls.
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;
    int          stall_tick = 0;

    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 96);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_COIN:  result_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:     result_stall <= (stall_tick % 3 != 0);
        endcase
    end

    // Hard stop: the slowest legal run is well under a tenth of this
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic vote_request_t mk_req(input logic act,
                                             input logic [TRIT_W-1:0] ta,
                                             input logic [TRIT_W-1:0] tb,
                                             input logic [TRIT_W-1:0] tc,
                                             input int blk, input int lbl,
                                             input logic last);
        vote_request_t r;
        r.act  = act;
        r.ta   = ta;
        r.tb   = tb;
        r.tc   = tc;
        r.blk  = BLK_W'(blk);
        r.lbl  = LBL_W'(lbl);
        r.last = last;
        return r;
    endfunction

    // Mostly legal trits; the odd clamp pattern still turns up
    function automatic logic [TRIT_W-1:0] rand_trit();
        logic [TRIT_W-1:0] t;
        if ($urandom_range(0, 9) == 0)
            t = TRIT_CLAMP;
        else
            case ($urandom_range(0, 2))
                0:       t = TRIT_NEG;
                1:       t = TRIT_ZERO;
                default: t = TRIT_POS;
            endcase
        return t;
    endfunction

    // A small pool of blocks keeps the table dense enough for real votes;
    // the rest spread over the full range and beyond it.
    function automatic int rand_block();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 17)
            return $urandom_range(0, 5);
        else if (roll < 19)
            return $urandom_range(0, NUM_BLOCKS_DEF - 1);
        return $urandom_range(NUM_BLOCKS_DEF, 127);
    endfunction

    function automatic vote_request_t rand_req(input logic act, input logic last);
        int lbl;
        lbl = ($urandom_range(0, 14) == 0) ? $urandom_range(NUM_CLASSES_DEF, 15)
                                           : $urandom_range(0, NUM_CLASSES_DEF - 1);
        return mk_req(act, rand_trit(), rand_trit(), rand_trit(), rand_block(), lbl, last);
    endfunction

    // Present one request and hold it until the block takes it. Valid stays
    // high on return; the pacing below decides whether it drops.
    task automatic send(input vote_request_t r);
        item_valid  <= 1'b1;
        action      <= r.act;
        trit_a      <= r.ta;
        trit_b      <= r.tb;
        trit_c      <= r.tc;
        block_index <= r.blk;
        class_label <= r.lbl;
        last_block  <= r.last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_total++;
        if (r.act == ACT_TRAIN)
            sent_train++;
        else
        begin
            sent_classify++;
            if (r.last)
                sent_samples++;
        end
    endtask

    // Bursts of random length separated by random gaps; now and then a long
    // burst gives a stretch with no idling at all.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_paced(input vote_request_t r);
        send(r);
        pace();
    endtask

    // Drop valid and wait for every predicted result, then let any train
    // request still in the pipeline finish.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip_code(input int code);
        cfg_we   <= 1'b1;
        cfg_data <= CODE_W'(code);
        @(posedge clk);
        cfg_we   <= 1'b0;
        phase_count++;
    endtask

    // One step of random traffic: mostly a little training followed by a
    // complete sample, otherwise a single request of pure noise or a pause.
    task automatic random_step();
        int roll;
        int n;
        roll = $urandom_range(0, 19);
        if (roll < 15)
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                send_paced(rand_req(ACT_TRAIN, $urandom_range(0, 9) == 0));
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                send_paced(rand_req(ACT_CLASSIFY, k == n - 1));
        end
        else if (roll < 19)
            send_paced(mk_req(1'($urandom_range(0, 1)),
                              TRIT_W'($urandom_range(0, 3)),
                              TRIT_W'($urandom_range(0, 3)),
                              TRIT_W'($urandom_range(0, 3)),
                              $urandom_range(0, 127), $urandom_range(0, 15),
                              1'($urandom_range(0, 1))));
        else
            drain();
    endtask

    initial
    begin
        int phase_start;
        int code;

        // reset, then the block clears its table with item_stall high;
        // requests simply wait on the handshake through that pass
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, background code left at its reset value ----
        // empty table: all totals tie, lowest class wins
        send(mk_req(ACT_CLASSIFY, TRIT_NEG, TRIT_NEG, TRIT_NEG, 0, 0, 1'b1));
        send(mk_req(ACT_TRAIN, TRIT_NEG, TRIT_NEG, TRIT_NEG, 0, 9, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_POS, TRIT_POS, 83, 3, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_POS, TRIT_POS, 83, 3, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_POS, TRIT_POS, 83, 7, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_POS, TRIT_POS, 83, 7, 1'b0));
        // clamp pattern lands on the same code as all -1
        send(mk_req(ACT_TRAIN, TRIT_CLAMP, TRIT_CLAMP, TRIT_CLAMP, 5, 4, 1'b0));
        // block out of range, just and far; bad label; last on a train
        send(mk_req(ACT_TRAIN, TRIT_ZERO, TRIT_ZERO, TRIT_ZERO, 127, 1, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_NEG, TRIT_ZERO, 84, 0, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_ZERO, TRIT_POS, TRIT_NEG, 1, 15, 1'b0));
        send(mk_req(ACT_TRAIN, TRIT_ZERO, TRIT_ZERO, TRIT_ZERO, 2, 2, 1'b1));
        send(mk_req(ACT_TRAIN, TRIT_ZERO, TRIT_ZERO, TRIT_ZERO, 2, 0, 1'b0));
        // tie between two trained classes
        send(mk_req(ACT_CLASSIFY, TRIT_POS, TRIT_POS, TRIT_POS, 83, 10, 1'b1));
        // two blocks in one sample, one of them via the clamp pattern
        send(mk_req(ACT_CLASSIFY, TRIT_NEG, TRIT_NEG, TRIT_NEG, 0, 0, 1'b0));
        send(mk_req(ACT_CLASSIFY, TRIT_CLAMP, TRIT_CLAMP, TRIT_CLAMP, 5, 9, 1'b1));
        // background code is skipped even though its row holds votes
        send(mk_req(ACT_CLASSIFY, TRIT_ZERO, TRIT_ZERO, TRIT_ZERO, 2, 0, 1'b1));
        // out-of-range blocks add nothing but still give a result
        send(mk_req(ACT_CLASSIFY, TRIT_ZERO, TRIT_ZERO, TRIT_ZERO, 127, 15, 1'b1));
        send(mk_req(ACT_CLASSIFY, TRIT_ZERO, TRIT_POS, TRIT_NEG, 1, 0, 1'b0));
        send(mk_req(ACT_CLASSIFY, TRIT_POS, TRIT_NEG, TRIT_ZERO, 84, 0, 1'b1));
        // break the tie, then check the winner moves
        send(mk_req(ACT_TRAIN, TRIT_POS, TRIT_POS, TRIT_POS, 83, 7, 1'b0));
        send(mk_req(ACT_CLASSIFY, TRIT_POS, TRIT_POS, TRIT_POS, 83, 0, 1'b0));
        send(mk_req(ACT_CLASSIFY, TRIT_NEG, TRIT_NEG, TRIT_NEG, 0, 0, 1'b1));

        // ---- random part: one background code per phase ----
        // the first phases pin the extremes: zero, top legal code, and two
        // codes above the legal range that must never match
        while (sent_total < ITEM_TARGET || sent_samples < RESULT_TARGET)
        begin
            drain();
            case (phase_count)
                0:       code = 0;
                1:       code = CODES - 1;
                2:       code = 31;
                3:       code = CODES;
                default: code = $urandom_range(0, 31);
            endcase
            write_skip_code(code);
            phase_start = sent_total;
            while (sent_total - phase_start < PHASE_ITEMS &&
                   (sent_total < ITEM_TARGET || sent_samples < RESULT_TARGET))
                random_step();
        end

        drain();

        $display("Covered %0d requests (%0d train, %0d classify), %0d class results",
                 sent_total, sent_train, sent_classify, sent_samples);
        $display("Ran %0d background code settings after the reset default",
                 phase_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
